// File: hw/rtl/signed_multi_digit_seven_segment_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the seven-segment decoder core.
// ----------------------------------------------------------------------------
`ifndef SIGNED_MULTI_DIGIT_SEVEN_SEGMENT_DECODER_CORE_MACROS_SVH
`define SIGNED_MULTI_DIGIT_SEVEN_SEGMENT_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SMSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/smsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsd_pkg
// Types, register indexes and glyph table of the seven-segment decoder.
// ----------------------------------------------------------------------------
package smsd_pkg;

	localparam logic [1:0] REG_ZERO_FILL      = 2'd0;
	localparam logic [1:0] REG_POINT_POSITION = 2'd1;

	localparam logic [6:0] GLYPH_MINUS     = 7'h01;
	localparam logic [6:0] GLYPH_MINUS_ONE = 7'h31;

	// ceil(2^35 / 10): exact quotient for every 32-bit magnitude
	localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

	typedef struct packed {
		logic        zero_fill;
		logic [2:0]  point_position;
	} cfg_t;

	typedef struct packed {
		logic [31:0] mag;
		logic        neg;
		logic        minus_one;
		logic        is_zero;
	} item_t;

	typedef struct packed {
		logic [2:0]  digit_index;
		logic [6:0]  segments;
		logic        lit;
		logic        point_on;
		logic        final_digit;
	} result_t;

	function automatic logic [6:0] digit_glyph(input logic [3:0] d);
		logic [6:0] g;
		unique case (d)
			4'd0: g = 7'h7E;
			4'd1: g = 7'h30;
			4'd2: g = 7'h6D;
			4'd3: g = 7'h79;
			4'd4: g = 7'h33;
			4'd5: g = 7'h5B;
			4'd6: g = 7'h5F;
			4'd7: g = 7'h72;
			4'd8: g = 7'h7F;
			4'd9: g = 7'h7B;
			default: g = 7'h00;
		endcase
		return g;
	endfunction

endpackage

// File: hw/rtl/signed_multi_digit_seven_segment_decoder_core.sv
`timescale 1ns / 1ps
// Path: a number is queued, loaded into the digit stepper, and each digit is
// registered into the result queue before it pops. Throughput: one result
// beat per cycle while that queue has room; the stepper divides by ten per beat.
// Reset: arst_n clears both queues, the stepper and the config registers.
// ----------------------------------------------------------------------------
// signed_multi_digit_seven_segment_decoder_core
// Signed number to per-digit seven-segment patterns, least significant first.
// ----------------------------------------------------------------------------
`include "signed_multi_digit_seven_segment_decoder_core_macros.svh"

module signed_multi_digit_seven_segment_decoder_core #(
	parameter int DIGITS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] number,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         digit_index,
	output logic [6:0]         segments,
	output logic               lit,
	output logic               point_on,
	output logic               final_digit,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [2:0]         cfg_data
);

	smsd_pkg::cfg_t    cfg_q;
	smsd_pkg::item_t   item;
	smsd_pkg::result_t res;
	logic              item_empty;
	logic              item_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				smsd_pkg::REG_ZERO_FILL:      cfg_q.zero_fill      <= cfg_data[0];
				smsd_pkg::REG_POINT_POSITION: cfg_q.point_position <= cfg_data;
				default:                      cfg_q                <= cfg_q;
			endcase
		end
	end

	smsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.number     (number),
		.full       (full),
		.item_pop   (item_pop),
		.item       (item),
		.item_empty (item_empty)
	);

	smsd_back #(
		.DIGITS(DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.item_empty (item_empty),
		.item_pop   (item_pop),
		.pop        (pop),
		.res        (res),
		.empty      (empty)
	);

	assign digit_index = res.digit_index;
	assign segments    = res.segments;
	assign lit         = res.lit;
	assign point_on    = res.point_on;
	assign final_digit = res.final_digit;

	`SMSD_ASSERT_IMPL(a_final_on_top, clk, arst_n, !empty, final_digit == (digit_index == 3'(DIGITS - 1)), "final flag off the top digit")
	`SMSD_ASSERT_IMPL(a_blank_dark, clk, arst_n, !empty && !lit, segments == 7'd0, "blanked digit has segments")
	`SMSD_ASSERT_IMPL(a_point_lit, clk, arst_n, !empty && point_on, lit, "point on a blanked digit")
	`SMSD_ASSERT_NEXT(a_index_step, clk, arst_n, pop && !empty && !final_digit && !(push && !full), empty || (digit_index == $past(digit_index) + 3'd1), "digit order broken")

endmodule

// File: hw/rtl/smsd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsd_fifo
// Two-entry queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module smsd_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             wr_en;
	logic             rd_en;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign wr_en   = push && !full;
	assign rd_en   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/smsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsd_front
// Accepts numbers, splits sign and magnitude, flags special cases, queues.
// ----------------------------------------------------------------------------
module smsd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic signed [31:0]    number,
	output logic                  full,
	input  logic                  item_pop,
	output smsd_pkg::item_t       item,
	output logic                  item_empty
);

	smsd_pkg::item_t cls;
	logic [31:0]     raw;

	// classify the incoming beat
	always_comb begin
		raw           = unsigned'(number);
		cls.neg       = raw[31];
		cls.mag       = raw[31] ? (32'd0 - raw) : raw;
		cls.minus_one = (cls.mag >= 32'd100) && (cls.mag <= 32'd199);
		cls.is_zero   = (raw == 32'd0);
	end

	smsd_fifo #(
		.WIDTH($bits(smsd_pkg::item_t))
	) u_item_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cls),
		.full    (full),
		.pop     (item_pop),
		.rd_data (item),
		.empty   (item_empty)
	);

endmodule

// File: hw/rtl/smsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsd_back
// Digit stepper: one digit per cycle into the result queue while it is not full.
// ----------------------------------------------------------------------------
module smsd_back #(
	parameter int DIGITS = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  smsd_pkg::cfg_t        cfg,
	input  smsd_pkg::item_t       item,
	input  logic                  item_empty,
	output logic                  item_pop,
	input  logic                  pop,
	output smsd_pkg::result_t     res,
	output logic                  empty
);

	localparam logic [2:0] LAST_IDX = 3'(DIGITS - 1);
	localparam logic [3:0] DIGITS_W = 4'(DIGITS);

	logic              busy_q;
	logic [2:0]        idx_q;
	logic [31:0]       mag_q;
	logic              neg_q;
	logic              minus_one_q;
	logic              is_zero_q;

	logic              res_full;
	logic              step;
	logic              last;
	logic [63:0]       prod;
	logic [31:0]       quot;
	logic [3:0]        rem;
	logic              point_en;
	logic              lit;
	logic [6:0]        seg;
	smsd_pkg::result_t res_d;

	assign step     = busy_q && !res_full;
	assign last     = (idx_q == LAST_IDX);
	assign item_pop = !item_empty && (!busy_q || (step && last));
	assign point_en = (cfg.point_position != 3'd0) &&
		({1'b0, cfg.point_position} < DIGITS_W);

	always_comb begin
		prod = {32'd0, mag_q} * {32'd0, smsd_pkg::RECIP_10};
		quot = {3'd0, prod[63:35]};
		rem  = mag_q[3:0] - {quot[0], 3'd0} - {quot[2:0], 1'b0};

		if (cfg.zero_fill) begin
			lit = 1'b1;
		end else if (point_en && (idx_q <= cfg.point_position)) begin
			lit = 1'b1;
		end else begin
			lit = (mag_q != 32'd0);
		end
		seg = smsd_pkg::digit_glyph(rem);
		if (is_zero_q && (idx_q == 3'd0)) begin
			lit = 1'b1;
		end
		if (neg_q && last) begin
			seg = minus_one_q ? smsd_pkg::GLYPH_MINUS_ONE : smsd_pkg::GLYPH_MINUS;
			lit = 1'b1;
		end
		if (!lit) begin
			seg = 7'd0;
		end

		res_d.digit_index = idx_q;
		res_d.segments    = seg;
		res_d.lit         = lit;
		res_d.point_on    = point_en && (idx_q == cfg.point_position);
		res_d.final_digit = last;
	end

	// load a new item, advance one digit per beat
	always_ff @(posedge clk) begin
		if (item_pop) begin
			mag_q       <= item.mag;
			neg_q       <= item.neg;
			minus_one_q <= item.minus_one;
			is_zero_q   <= item.is_zero;
		end else if (step) begin
			mag_q       <= quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else begin
			if (item_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 3'd0;
			end else if (step) begin
				if (last) begin
					busy_q <= 1'b0;
					idx_q  <= 3'd0;
				end else begin
					idx_q  <= idx_q + 3'd1;
				end
			end
		end
	end

	smsd_fifo #(
		.WIDTH($bits(smsd_pkg::result_t))
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (step),
		.wr_data (res_d),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res),
		.empty   (empty)
	);

endmodule

// File: dv/smsd_digit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsd_digit_checker
// Watches the number, digit and register channels of the seven-segment
// decoder. It predicts the digit beats for every accepted number from its own
// copy of the registers and compares each popped beat field by field.
// ----------------------------------------------------------------------------
module smsd_digit_checker #(
	parameter int DIGITS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic signed [31:0] number,
	input  logic               empty,
	input  logic               pop,
	input  logic [2:0]         digit_index,
	input  logic [6:0]         segments,
	input  logic               lit,
	input  logic               point_on,
	input  logic               final_digit,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [2:0]         cfg_data,
	output int                 fail_count,
	output int                 digits_owed
);
	import smsd_pkg::*;

	localparam logic [9:0][6:0] SEG_OF_DIGIT = {
		7'h7B, 7'h7F, 7'h72, 7'h5F, 7'h5B, 7'h33, 7'h79, 7'h6D, 7'h30, 7'h7E
	};

	logic       fill_q;
	logic [2:0] point_q;
	result_t    expected_digits [$];

	task automatic predict_digits(input logic [31:0] raw);
		logic [31:0] whole;
		logic [31:0] rest;
		logic [3:0]  d;
		logic        neg;
		logic        point_en;
		logic        last;
		logic        shown;
		logic [6:0]  seg;
		result_t     r;
		int          i;
		neg = raw[31];
		whole = neg ? (32'd0 - raw) : raw;
		rest = whole;
		point_en = (point_q != 3'd0) && (int'(point_q) < DIGITS);
		for (i = 0; i < DIGITS; i++) begin
			d = 4'(rest % 32'd10);
			last = (i == DIGITS - 1);
			if (fill_q)
				shown = 1'b1;
			else if (point_en && i <= int'(point_q))
				shown = 1'b1;
			else
				shown = (rest != 32'd0);
			seg = SEG_OF_DIGIT[d];
			if (raw == 32'd0 && i == 0)
				shown = 1'b1;
			if (neg && last) begin
				seg = (whole >= 32'd100 && whole <= 32'd199) ? GLYPH_MINUS_ONE : GLYPH_MINUS;
				shown = 1'b1;
			end
			if (!shown)
				seg = 7'h00;
			r.digit_index = 3'(i);
			r.segments = seg;
			r.lit = shown;
			r.point_on = point_en && (i == int'(point_q));
			r.final_digit = last;
			expected_digits.insert(expected_digits.size(), r);
			rest = rest / 32'd10;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		logic    bad;
		if (!arst_n) begin
			fill_q = 1'b0;
			point_q = 3'd0;
			expected_digits.delete();
			fail_count = 0;
			digits_owed = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ZERO_FILL: fill_q = cfg_data[0];
					REG_POINT_POSITION: point_q = cfg_data;
					default: ;
				endcase
			end
			if (push && !full)
				predict_digits(number);
			if (pop && !empty) begin
				if (expected_digits.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected digit beat: idx=%0d seg=%h lit=%b pt=%b last=%b",
							digit_index, segments, lit, point_on, final_digit);
				end else begin
					want = expected_digits.pop_front();
					bad = 1'b0;
					if (digit_index !== want.digit_index) bad = 1'b1;
					if (segments !== want.segments) bad = 1'b1;
					if (lit !== want.lit) bad = 1'b1;
					if (point_on !== want.point_on) bad = 1'b1;
					if (final_digit !== want.final_digit) bad = 1'b1;
					if (bad) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"digit mismatch: exp idx=%0d seg=%h lit=%b pt=%b last=%b",
								" | got idx=%0d seg=%h lit=%b pt=%b last=%b"},
								want.digit_index, want.segments, want.lit, want.point_on,
								want.final_digit, digit_index, segments, lit, point_on,
								final_digit);
					end
				end
			end
			digits_owed = expected_digits.size();
		end
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives signed numbers and register writes into the seven-segment decoder
// with random gaps and stalls, and a long pop hold-off that fills the block.
// The checker beside the block predicts and compares every digit beat.
// ----------------------------------------------------------------------------
module tb;
	import smsd_pkg::*;

	localparam int DIGITS = 3;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_LIMIT = 5000;
	localparam int PHASES = 8;
	localparam int PER_PHASE = 50;
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic signed [31:0] number;
	logic               empty;
	logic               pop;
	logic [2:0]         digit_index;
	logic [6:0]         segments;
	logic               lit;
	logic               point_on;
	logic               final_digit;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [2:0]         cfg_data;
	int                 fail_count;
	int                 digits_owed;
	logic               idle_on;
	logic               hold_req;
	int                 quiet_cycles;

	signed_multi_digit_seven_segment_decoder_core #(.DIGITS(DIGITS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .number(number),
		.empty(empty), .pop(pop),
		.digit_index(digit_index), .segments(segments), .lit(lit),
		.point_on(point_on), .final_digit(final_digit),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	smsd_digit_checker #(.DIGITS(DIGITS)) u_check (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .number(number),
		.empty(empty), .pop(pop),
		.digit_index(digit_index), .segments(segments), .lit(lit),
		.point_on(point_on), .final_digit(final_digit),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .digits_owed(digits_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : digit_sink
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				gap = idle_on ? int'($urandom_range(0, 6)) : 0;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	function automatic logic [31:0] pick_number();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = 32'(int'($urandom_range(0, 2000)) - 1000);
			2: v = 32'(-int'($urandom_range(100, 199)));
			3: v = 32'(int'($urandom_range(0, 20)) - 10);
			4: v = 32'(int'($urandom_range(0, 200000)) - 100000);
			default: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'hFFFF_FFFF;
					default: v = 32'h0;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic send_number(input logic [31:0] v);
		int gap;
		gap = idle_on ? int'($urandom_range(0, 6)) : 0;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		number <= v;
		do @(posedge clk); while (full);
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (digits_owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [31:0] corner_numbers [$];
		logic        fill_set [PHASES];
		logic [2:0]  point_set [PHASES];
		int          p;
		int          k;
		corner_numbers = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'd99, 32'd100,
			-32'sd100, 32'd199, -32'sd199, -32'sd200, -32'sd99, 32'd999, 32'd1000,
			-32'sd1000, 32'd123456, 32'h7FFF_FFFF, 32'h8000_0000, -32'sd150, 32'd5,
			32'd8, 32'd42, -32'sd10, 32'd7, 32'd200};
		fill_set = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		point_set = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd7, 3'd1, 3'd0};
		arst_n = 1'b0;
		push = 1'b0;
		number = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ZERO_FILL;
		cfg_data = 3'd0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_ZERO_FILL, 3'd0);
		write_reg(REG_POINT_POSITION, 3'd0);
		foreach (corner_numbers[k])
			send_number(corner_numbers[k]);

		for (p = 0; p < PHASES; p++) begin
			drain();
			write_reg(REG_ZERO_FILL, {3'($urandom_range(0, 3)) << 1} | {2'b00, fill_set[p]});
			write_reg(REG_POINT_POSITION, point_set[p]);
			if (p == 2 || p == 5) begin
				write_reg(REG_SPARE_A, 3'($urandom_range(0, 7)));
				write_reg(REG_SPARE_B, 3'($urandom_range(0, 7)));
			end
			idle_on = (p != 3);
			if (p == 4)
				hold_req = 1'b1;
			for (k = 0; k < PER_PHASE; k++)
				send_number(pick_number());
		end

		drain();
		if (fail_count == 0 && digits_owed == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
